@@ hw/rtl/escp_pkg.sv @@
`default_nettype none
package escp_pkg;

   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 64;

   localparam logic [CsrIdxW-1:0] CSR_TEMP_CALIB    = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_PRESS_CALIB_A = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_PRESS_CALIB_B = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_PRESS_CALIB_C = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_HUM_CALIB_A   = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_HUM_CALIB_B   = 3'd5;

   localparam logic [31:0] TEMP_PRESS_OFS = 32'd64000;
   localparam logic [31:0] TEMP_HUM_OFS   = 32'd76800;
   localparam logic [31:0] PRESS_BASE     = 32'd1048576;
   localparam logic [31:0] PRESS_SCALE    = 32'd3125;
   localparam logic [31:0] HUM_LIMIT      = 32'd419430400;
   localparam logic [31:0] HUM_OFS        = 32'd2097152;
   localparam logic [31:0] RND_16384      = 32'd16384;
   localparam logic [31:0] RND_32768      = 32'd32768;
   localparam logic [31:0] RND_8192       = 32'd8192;
   localparam logic [16:0] HUM_Q10_MAX    = 17'd102400;

   // calibration words, already widened to 32 bits
   typedef struct packed {
      logic [31:0] t1;
      logic [31:0] t2;
      logic [31:0] t3;
      logic [31:0] p1;
      logic [31:0] p2;
      logic [31:0] p3;
      logic [31:0] p4;
      logic [31:0] p5;
      logic [31:0] p6;
      logic [31:0] p7;
      logic [31:0] p8;
      logic [31:0] p9;
      logic [31:0] h1;
      logic [31:0] h2;
      logic [31:0] h3;
      logic [31:0] h4;
      logic [31:0] h5;
      logic [31:0] h6;
   } calib_type;

   // fields that ride alongside the pressure division
   typedef struct packed {
      logic [31:0] tc;
      logic [31:0] tf;
      logic [16:0] hum;
      logic        invalid;
      logic        dbl;
   } side_type;

   function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
      logic signed [31:0] s;
      s = $signed(x) >>> n;
      return $unsigned(s);
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/escp_req_if.sv @@
`default_nettype none
interface escp_req_if;
   logic        valid;
   logic        ready;
   logic [19:0] raw_temperature;
   logic [19:0] raw_pressure;
   logic [15:0] raw_humidity;

   modport source (output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
   modport sink (input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/escp_rsp_if.sv @@
`default_nettype none
interface escp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] temperature_centi;
   logic signed [31:0] fine_temperature;
   logic [31:0]        pressure_pa;
   logic               pressure_invalid;
   logic [16:0]        humidity_q10;

   modport source (output valid, temperature_centi, fine_temperature, pressure_pa,
                   pressure_invalid, humidity_q10, input ready);
   modport sink (input valid, temperature_centi, fine_temperature, pressure_pa,
                 pressure_invalid, humidity_q10, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/escp_front.sv @@
`default_nettype none
module escp_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic [19:0]         raw_t,
   input  wire logic [19:0]         raw_p,
   input  wire logic [15:0]         raw_h,
   input  wire escp_pkg::calib_type cal,
   output logic                     out_valid,
   output escp_pkg::side_type       out_side,
   output logic [31:0]              out_dividend,
   output logic [31:0]              out_divisor
);
   localparam int Stages = 14;

   logic [Stages-1:0] vld_ff;

   logic [19:0] s1_t_ff, s1_p_ff, s2_p_ff, s3_p_ff, s4_p_ff, s5_p_ff, s6_p_ff, s7_p_ff, s8_p_ff;
   logic [15:0] s1_h_ff, s2_h_ff, s3_h_ff, s4_h_ff, s5_h_ff, s6_h_ff;
   logic [31:0] s2_m1_ff, s2_m2_ff, s3_a_ff, s3_m3_ff, s4_tf_ff;
   logic [31:0] s5_tc_ff, s5_tf_ff, s5_pa_ff, s5_ha_ff;
   logic [31:0] s6_tc_ff, s6_tf_ff, s6_d_ff, s6_a5_ff, s6_p2a_ff, s6_h5a_ff, s6_ah6_ff, s6_ah3_ff;
   logic [31:0] s7_tc_ff, s7_tf_ff, s7_b1_ff, s7_a5_ff, s7_p3d_ff, s7_p2a_ff, s7_bh_ff, s7_x_ff;
   logic [31:0] s8_tc_ff, s8_tf_ff, s8_b3_ff, s8_pq_ff, s8_dh_ff, s8_bh_ff;
   logic [31:0] s9_tc_ff, s9_tf_ff, s9_pa2_ff, s9_num_ff, s9_hm_ff, s9_bh_ff;
   logic [31:0] s10_tc_ff, s10_tf_ff, s10_div_ff, s10_nm_ff, s10_dh2_ff, s10_bh_ff;
   logic [31:0] s11_tc_ff, s11_tf_ff, s11_hb_ff, s11_dvd_ff, s11_dsr_ff;
   logic        s11_dbl_ff, s11_inv_ff;
   logic [31:0] s12_tc_ff, s12_tf_ff, s12_hb_ff, s12_sq_ff, s12_dvd_ff, s12_dsr_ff;
   logic        s12_dbl_ff, s12_inv_ff;
   logic [31:0] s13_tc_ff, s13_tf_ff, s13_hb_ff, s13_t_ff, s13_dvd_ff, s13_dsr_ff;
   logic        s13_dbl_ff, s13_inv_ff;
   escp_pkg::side_type s14_side_ff;
   logic [31:0] s14_dvd_ff, s14_dsr_ff;

   logic [31:0] adc_t, dd, pq, hd, hum_a, hum_c;

   assign adc_t = {12'd0, s1_t_ff};
   assign dd    = (adc_t >> 4) - cal.t1;
   assign pq    = escp_pkg::asr(s5_pa_ff, 2);
   assign hd    = escp_pkg::asr(s11_hb_ff, 15);
   assign hum_a = s13_hb_ff - escp_pkg::asr(s13_t_ff, 4);

   always_comb begin
      hum_c = hum_a;
      if (hum_a[31]) begin
         hum_c = '0;
      end else if (hum_a > escp_pkg::HUM_LIMIT) begin
         hum_c = escp_pkg::HUM_LIMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[Stages-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_t_ff <= raw_t;
         s1_p_ff <= raw_p;
         s1_h_ff <= raw_h;

         s2_m1_ff <= ((adc_t >> 3) - (cal.t1 << 1)) * cal.t2;
         s2_m2_ff <= dd * dd;
         s2_p_ff  <= s1_p_ff;
         s2_h_ff  <= s1_h_ff;

         s3_a_ff  <= escp_pkg::asr(s2_m1_ff, 11);
         s3_m3_ff <= escp_pkg::asr(s2_m2_ff, 12) * cal.t3;
         s3_p_ff  <= s2_p_ff;
         s3_h_ff  <= s2_h_ff;

         s4_tf_ff <= s3_a_ff + escp_pkg::asr(s3_m3_ff, 14);
         s4_p_ff  <= s3_p_ff;
         s4_h_ff  <= s3_h_ff;

         s5_tc_ff <= escp_pkg::asr((s4_tf_ff << 2) + s4_tf_ff + 32'd128, 8);
         s5_tf_ff <= s4_tf_ff;
         s5_pa_ff <= escp_pkg::asr(s4_tf_ff, 1) - escp_pkg::TEMP_PRESS_OFS;
         s5_ha_ff <= s4_tf_ff - escp_pkg::TEMP_HUM_OFS;
         s5_p_ff  <= s4_p_ff;
         s5_h_ff  <= s4_h_ff;

         s6_tc_ff  <= s5_tc_ff;
         s6_tf_ff  <= s5_tf_ff;
         s6_d_ff   <= pq * pq;
         s6_a5_ff  <= s5_pa_ff * cal.p5;
         s6_p2a_ff <= cal.p2 * s5_pa_ff;
         s6_h5a_ff <= cal.h5 * s5_ha_ff;
         s6_ah6_ff <= s5_ha_ff * cal.h6;
         s6_ah3_ff <= s5_ha_ff * cal.h3;
         s6_p_ff   <= s5_p_ff;
         s6_h_ff   <= s5_h_ff;

         s7_tc_ff  <= s6_tc_ff;
         s7_tf_ff  <= s6_tf_ff;
         s7_b1_ff  <= escp_pkg::asr(s6_d_ff, 11) * cal.p6;
         s7_a5_ff  <= s6_a5_ff;
         s7_p3d_ff <= cal.p3 * escp_pkg::asr(s6_d_ff, 13);
         s7_p2a_ff <= s6_p2a_ff;
         s7_bh_ff  <= escp_pkg::asr(({16'd0, s6_h_ff} << 14) - (cal.h4 << 20) - s6_h5a_ff
                                    + escp_pkg::RND_16384, 15);
         s7_x_ff   <= escp_pkg::asr(s6_ah6_ff, 10)
                      * (escp_pkg::asr(s6_ah3_ff, 11) + escp_pkg::RND_32768);
         s7_p_ff   <= s6_p_ff;

         s8_tc_ff <= s7_tc_ff;
         s8_tf_ff <= s7_tf_ff;
         s8_b3_ff <= escp_pkg::asr(s7_b1_ff + (s7_a5_ff << 1), 2) + (cal.p4 << 16);
         s8_pq_ff <= escp_pkg::asr(escp_pkg::asr(s7_p3d_ff, 3) + escp_pkg::asr(s7_p2a_ff, 1), 18);
         s8_dh_ff <= escp_pkg::asr(s7_x_ff, 10) + escp_pkg::HUM_OFS;
         s8_bh_ff <= s7_bh_ff;
         s8_p_ff  <= s7_p_ff;

         s9_tc_ff  <= s8_tc_ff;
         s9_tf_ff  <= s8_tf_ff;
         s9_pa2_ff <= (escp_pkg::RND_32768 + s8_pq_ff) * cal.p1;
         s9_num_ff <= (escp_pkg::PRESS_BASE - {12'd0, s8_p_ff}) - escp_pkg::asr(s8_b3_ff, 12);
         s9_hm_ff  <= s8_dh_ff * cal.h2;
         s9_bh_ff  <= s8_bh_ff;

         s10_tc_ff  <= s9_tc_ff;
         s10_tf_ff  <= s9_tf_ff;
         s10_div_ff <= escp_pkg::asr(s9_pa2_ff, 15);
         s10_nm_ff  <= s9_num_ff * escp_pkg::PRESS_SCALE;
         s10_dh2_ff <= escp_pkg::asr(s9_hm_ff + escp_pkg::RND_8192, 14);
         s10_bh_ff  <= s9_bh_ff;

         // a numerator with the top bit set is divided first and doubled after
         s11_tc_ff  <= s10_tc_ff;
         s11_tf_ff  <= s10_tf_ff;
         s11_hb_ff  <= s10_bh_ff * s10_dh2_ff;
         s11_dbl_ff <= s10_nm_ff[31];
         s11_dvd_ff <= s10_nm_ff[31] ? s10_nm_ff : (s10_nm_ff << 1);
         s11_dsr_ff <= s10_div_ff;
         s11_inv_ff <= (s10_div_ff == '0);

         s12_tc_ff  <= s11_tc_ff;
         s12_tf_ff  <= s11_tf_ff;
         s12_hb_ff  <= s11_hb_ff;
         s12_sq_ff  <= hd * hd;
         s12_dvd_ff <= s11_dvd_ff;
         s12_dsr_ff <= s11_dsr_ff;
         s12_dbl_ff <= s11_dbl_ff;
         s12_inv_ff <= s11_inv_ff;

         s13_tc_ff  <= s12_tc_ff;
         s13_tf_ff  <= s12_tf_ff;
         s13_hb_ff  <= s12_hb_ff;
         s13_t_ff   <= escp_pkg::asr(s12_sq_ff, 7) * cal.h1;
         s13_dvd_ff <= s12_dvd_ff;
         s13_dsr_ff <= s12_dsr_ff;
         s13_dbl_ff <= s12_dbl_ff;
         s13_inv_ff <= s12_inv_ff;

         s14_side_ff.tc      <= s13_tc_ff;
         s14_side_ff.tf      <= s13_tf_ff;
         s14_side_ff.hum     <= hum_c[28:12];
         s14_side_ff.invalid <= s13_inv_ff;
         s14_side_ff.dbl     <= s13_dbl_ff;
         s14_dvd_ff          <= s13_dvd_ff;
         s14_dsr_ff          <= s13_dsr_ff;
      end
   end

   assign out_valid    = vld_ff[Stages-1];
   assign out_side     = s14_side_ff;
   assign out_dividend = s14_dvd_ff;
   assign out_divisor  = s14_dsr_ff;

endmodule
`default_nettype wire

@@ hw/rtl/escp_div.sv @@
`default_nettype none
module escp_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire logic [31:0]        dividend,
   input  wire logic [31:0]        divisor,
   input  wire escp_pkg::side_type side_in,
   output logic                    out_valid,
   output logic [31:0]             quotient,
   output escp_pkg::side_type      side_out
);
   localparam int Steps = 32;

   logic [Steps-1:0]   vld_ff;
   logic [31:0]        rem_ff  [Steps];
   logic [31:0]        dvd_ff  [Steps];
   logic [31:0]        dsr_ff  [Steps];
   escp_pkg::side_type side_ff [Steps];

   logic [31:0]        rem_cur [Steps];
   logic [31:0]        dvd_cur [Steps];
   logic [31:0]        dsr_cur [Steps];
   escp_pkg::side_type side_cur[Steps];
   logic [31:0]        rem_in  [Steps];
   logic [31:0]        dvd_in  [Steps];

   always_comb begin
      logic [33:0] trial;
      rem_cur[0]  = '0;
      dvd_cur[0]  = dividend;
      dsr_cur[0]  = divisor;
      side_cur[0] = side_in;
      for (int j = 1; j < Steps; j++) begin
         rem_cur[j]  = rem_ff[j-1];
         dvd_cur[j]  = dvd_ff[j-1];
         dsr_cur[j]  = dsr_ff[j-1];
         side_cur[j] = side_ff[j-1];
      end
      // one quotient bit per stage, shifted in at the low end of the dividend word
      for (int j = 0; j < Steps; j++) begin
         trial = {1'b0, rem_cur[j], dvd_cur[j][31]} - {2'b00, dsr_cur[j]};
         if (trial[33]) begin
            rem_in[j] = {rem_cur[j][30:0], dvd_cur[j][31]};
            dvd_in[j] = {dvd_cur[j][30:0], 1'b0};
         end else begin
            rem_in[j] = trial[31:0];
            dvd_in[j] = {dvd_cur[j][30:0], 1'b1};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[Steps-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < Steps; j++) begin
            rem_ff[j]  <= rem_in[j];
            dvd_ff[j]  <= dvd_in[j];
            dsr_ff[j]  <= dsr_cur[j];
            side_ff[j] <= side_cur[j];
         end
      end
   end

   assign out_valid = vld_ff[Steps-1];
   assign quotient  = dvd_ff[Steps-1];
   assign side_out  = side_ff[Steps-1];

endmodule
`default_nettype wire

@@ hw/rtl/escp_back.sv @@
`default_nettype none
module escp_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic [31:0]         quotient,
   input  wire escp_pkg::side_type  side_in,
   input  wire escp_pkg::calib_type cal,
   output logic                     out_valid,
   output logic [31:0]              out_tc,
   output logic [31:0]              out_tf,
   output logic [31:0]              out_p,
   output logic                     out_invalid,
   output logic [16:0]              out_hum
);
   localparam int Stages = 4;

   logic [Stages-1:0]  vld_ff;
   escp_pkg::side_type b1_side_ff, b2_side_ff, b3_side_ff;
   logic [31:0]        b1_p_ff, b2_p_ff, b3_p_ff;
   logic [31:0]        b2_sq_ff, b2_m8_ff, b3_m9_ff, b3_b_ff;
   logic [31:0]        p3, corr;
   logic [31:0]        out_tc_ff, out_tf_ff, out_p_ff;
   logic               out_inv_ff;
   logic [16:0]        out_hum_ff;

   assign p3   = b1_p_ff >> 3;
   assign corr = escp_pkg::asr(escp_pkg::asr(b3_m9_ff, 12) + b3_b_ff + cal.p7, 4);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[Stages-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b1_side_ff <= side_in;
         b1_p_ff    <= side_in.dbl ? (quotient << 1) : quotient;

         b2_side_ff <= b1_side_ff;
         b2_p_ff    <= b1_p_ff;
         b2_sq_ff   <= p3 * p3;
         b2_m8_ff   <= (b1_p_ff >> 2) * cal.p8;

         b3_side_ff <= b2_side_ff;
         b3_p_ff    <= b2_p_ff;
         b3_m9_ff   <= cal.p9 * (b2_sq_ff >> 13);
         b3_b_ff    <= escp_pkg::asr(b2_m8_ff, 13);

         // force zero pressure when the divisor was zero
         out_tc_ff  <= b3_side_ff.tc;
         out_tf_ff  <= b3_side_ff.tf;
         out_p_ff   <= b3_side_ff.invalid ? '0 : (b3_p_ff + corr);
         out_inv_ff <= b3_side_ff.invalid;
         out_hum_ff <= b3_side_ff.hum;
      end
   end

   assign out_valid   = vld_ff[Stages-1];
   assign out_tc      = out_tc_ff;
   assign out_tf      = out_tf_ff;
   assign out_p       = out_p_ff;
   assign out_invalid = out_inv_ff;
   assign out_hum     = out_hum_ff;

endmodule
`default_nettype wire

@@ hw/rtl/environmental_sensor_compensation_core.sv @@
// Compensates one raw temperature/pressure/humidity frame per clock through
// 14 stages of multiply-and-shift arithmetic, a 32-stage restoring divider (one quotient bit
// per stage) for the pressure, and 4 stages of pressure correction ending in the output
// register. One frame enters every cycle; the whole pipeline holds while a finished result
// waits on rsp_ch.ready. Calibration words must be written through the csr_ port while no
// frame is in flight (not enforced by the block); writes to indexes past the sixth register are dropped.
`default_nettype none
module environmental_sensor_compensation_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   escp_req_if.sink                                  req_ch,
   escp_rsp_if.source                                rsp_ch,
   input  wire logic                                 csr_we,
   input  wire logic [escp_pkg::CsrIdxW-1:0]         csr_index,
   input  wire logic [escp_pkg::CsrDataW-1:0]        csr_wdata
);
   logic [47:0] temp_calib_ff;
   logic [63:0] press_a_ff, press_b_ff;
   logic [15:0] press_c_ff;
   logic [31:0] hum_a_ff, hum_b_ff;

   escp_pkg::calib_type cal;
   escp_pkg::side_type  front_side, div_side;
   logic        en, front_valid, div_valid, back_valid;
   logic [31:0] front_dvd, front_dsr, div_q;
   logic [31:0] out_tc, out_tf, out_p;
   logic        out_invalid;
   logic [16:0] out_hum;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_calib_ff <= '0;
         press_a_ff    <= '0;
         press_b_ff    <= '0;
         press_c_ff    <= '0;
         hum_a_ff      <= '0;
         hum_b_ff      <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            escp_pkg::CSR_TEMP_CALIB:    temp_calib_ff <= csr_wdata[47:0];
            escp_pkg::CSR_PRESS_CALIB_A: press_a_ff    <= csr_wdata;
            escp_pkg::CSR_PRESS_CALIB_B: press_b_ff    <= csr_wdata;
            escp_pkg::CSR_PRESS_CALIB_C: press_c_ff    <= csr_wdata[15:0];
            escp_pkg::CSR_HUM_CALIB_A:   hum_a_ff      <= csr_wdata[31:0];
            escp_pkg::CSR_HUM_CALIB_B:   hum_b_ff      <= csr_wdata[31:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cal.t1 = {16'd0, temp_calib_ff[15:0]};
      cal.t2 = {{16{temp_calib_ff[31]}}, temp_calib_ff[31:16]};
      cal.t3 = {{16{temp_calib_ff[47]}}, temp_calib_ff[47:32]};
      cal.p1 = {16'd0, press_a_ff[15:0]};
      cal.p2 = {{16{press_a_ff[31]}}, press_a_ff[31:16]};
      cal.p3 = {{16{press_a_ff[47]}}, press_a_ff[47:32]};
      cal.p4 = {{16{press_a_ff[63]}}, press_a_ff[63:48]};
      cal.p5 = {{16{press_b_ff[15]}}, press_b_ff[15:0]};
      cal.p6 = {{16{press_b_ff[31]}}, press_b_ff[31:16]};
      cal.p7 = {{16{press_b_ff[47]}}, press_b_ff[47:32]};
      cal.p8 = {{16{press_b_ff[63]}}, press_b_ff[63:48]};
      cal.p9 = {{16{press_c_ff[15]}}, press_c_ff};
      cal.h1 = {24'd0, hum_a_ff[7:0]};
      cal.h2 = {{16{hum_a_ff[23]}}, hum_a_ff[23:8]};
      cal.h3 = {24'd0, hum_a_ff[31:24]};
      cal.h4 = {{20{hum_b_ff[11]}}, hum_b_ff[11:0]};
      cal.h5 = {{20{hum_b_ff[23]}}, hum_b_ff[23:12]};
      cal.h6 = {{24{hum_b_ff[31]}}, hum_b_ff[31:24]};
   end

   // advance everything unless a finished result is held
   assign en           = !back_valid || rsp_ch.ready;
   assign req_ch.ready = en;

   escp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_ch.valid),
      .raw_t        (req_ch.raw_temperature),
      .raw_p        (req_ch.raw_pressure),
      .raw_h        (req_ch.raw_humidity),
      .cal          (cal),
      .out_valid    (front_valid),
      .out_side     (front_side),
      .out_dividend (front_dvd),
      .out_divisor  (front_dsr)
   );

   escp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .dividend  (front_dvd),
      .divisor   (front_dsr),
      .side_in   (front_side),
      .out_valid (div_valid),
      .quotient  (div_q),
      .side_out  (div_side)
   );

   escp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (div_valid),
      .quotient    (div_q),
      .side_in     (div_side),
      .cal         (cal),
      .out_valid   (back_valid),
      .out_tc      (out_tc),
      .out_tf      (out_tf),
      .out_p       (out_p),
      .out_invalid (out_invalid),
      .out_hum     (out_hum)
   );

   assign rsp_ch.valid             = back_valid;
   assign rsp_ch.temperature_centi = $signed(out_tc);
   assign rsp_ch.fine_temperature  = $signed(out_tf);
   assign rsp_ch.pressure_pa       = out_p;
   assign rsp_ch.pressure_invalid  = out_invalid;
   assign rsp_ch.humidity_q10      = out_hum;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.pressure_invalid) |-> (rsp_ch.pressure_pa == '0))
      else $error("pressure not zero on invalid divisor");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.humidity_q10 <= escp_pkg::HUM_Q10_MAX))
      else $error("humidity out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

   a_held_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=> (rsp_ch.valid && $stable(out_p) && $stable(out_tf)))
      else $error("held result changed");

endmodule
`default_nettype wire
